// File: hw/rtl/tdalm_pkg.sv
// tdalm_pkg: shared types, codes and sizes of the time-of-day alarm table
// no dependencies

package tdalm_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic       REG_ENTRY_COUNT  = 1'b0;
    localparam logic       REG_MODE_SETTING = 1'b1;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_TODAY = 2'd2;

    localparam logic [8:0]  NO_DAY    = 9'd511;
    localparam logic [10:0] NO_MINUTE = 11'd2047;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       etype;
        logic [7:0] sound;
    } entry_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [10:0] cur_min;
        logic [16:0] cur_sec;
    } now_t;

    typedef struct packed {
        logic        have_s;
        logic [16:0] best_s;
        logic        have_m;
        logic [10:0] best_m;
    } best_t;

    typedef struct packed {
        logic        match;
        logic        sec_upd;
        logic [16:0] sec_val;
        logic        min_upd;
        logic [10:0] min_val;
    } eval_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// File: hw/rtl/tdalm_table.sv
// tdalm_table: alarm entry storage, one write and one registered read per cycle
// depends on tdalm_pkg

module tdalm_table
    import tdalm_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/tdalm_eval.sv
// tdalm_eval: shared per-entry unit, time match and nearest later entry compare
// depends on tdalm_pkg

module tdalm_eval
    import tdalm_pkg::*;
(
    input  entry_t entry,
    input  now_t   now,
    input  best_t  best,
    output eval_t  res
);

    logic [10:0] em;
    logic [16:0] em_sec;

    always_comb begin
        em     = 11'({6'd0, entry.hour} * 11'd60) + 11'({5'd0, entry.minute});
        em_sec = 17'({6'd0, em} * 17'd60);

        res.match   = (entry.hour == now.hour) && (entry.minute == now.minute);
        res.sec_val = em_sec - now.cur_sec;
        res.sec_upd = (em_sec > now.cur_sec) && (!best.have_s || res.sec_val < best.best_s);
        res.min_val = em;
        res.min_upd = (em > now.cur_min) && (!best.have_m || em < best.best_m);
    end

endmodule

// File: hw/rtl/time_of_day_alarm_table.sv
// time_of_day_alarm_table: top level, sequencer, registers and result stage
// depends on tdalm_pkg, tdalm_table, tdalm_eval

// A write transaction stores one alarm entry and returns its result via the
// finish state and the output register; a tick that is inactive (clock not
// synced, mode off or no entries) takes the same path. An active tick walks
// the table one entry per cycle through the single read port of the entry
// memory and the shared evaluation unit, then the drain and finish states.
// Input is not accepted while a transaction is in progress; a finished result
// waits in the output register while the next transaction is taken. The table
// has no reset: only slots below entry_count that have been written give
// defined results.

module time_of_day_alarm_table
    import tdalm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [5:0]   cfg_wr_data,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_kind,
    input  logic [4:0]   s_entry_index,
    input  logic [4:0]   s_entry_hour,
    input  logic [5:0]   s_entry_minute,
    input  logic         s_entry_type,
    input  logic [7:0]   s_entry_sound,
    input  logic         s_time_synced,
    input  logic         s_stream_connected,
    input  logic [8:0]   s_day_of_year,
    input  logic [4:0]   s_hour_now,
    input  logic [5:0]   s_minute_now,
    input  logic [5:0]   s_second_now,

    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_ring,
    output logic         m_ring_type,
    output logic [7:0]   m_ring_sound,
    output logic         m_play_local,
    output logic signed [17:0] m_seconds_to_next,
    output logic signed [11:0] m_next_minute,
    output logic [1:0]   m_mode_now
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       mode_reg;
    logic [8:0]       last_day_reg;
    logic [10:0]      last_min_reg;

    logic [CNT_W-1:0] idx_reg;
    logic             rd_pend_reg;
    logic             active_reg;
    logic             fire_ok_reg;
    logic             stream_reg;
    logic [8:0]       day_reg;
    now_t             now_reg;
    best_t            best_reg;
    logic             found_reg;
    logic             found_type_reg;
    logic [7:0]       found_sound_reg;

    logic             m_valid_reg;
    logic             ring_reg;
    logic             ring_type_reg;
    logic [7:0]       ring_sound_reg;
    logic             play_local_reg;
    logic [17:0]      secs_reg;
    logic [11:0]      nmin_reg;
    logic [1:0]       mode_now_reg;

    logic             accept;
    logic             out_free;
    logic             finish;
    logic             last_issue;
    logic             tick_active;
    logic             wr_en;
    now_t             now_in;
    entry_t           wr_entry;
    entry_t           rd_entry;
    eval_t            ev;
    logic             fire;
    logic [1:0]       mode_after;
    logic [1:0]       mode_wr;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_issue = (idx_reg == cnt_reg - CNT_W'(1));

    assign tick_active = s_time_synced && (mode_reg != MODE_OFF) && (cnt_reg != '0);

    always_comb begin
        now_in.hour    = s_hour_now;
        now_in.minute  = s_minute_now;
        now_in.cur_min = 11'({6'd0, s_hour_now} * 11'd60) + 11'({5'd0, s_minute_now});
        now_in.cur_sec = 17'({12'd0, s_hour_now} * 17'd3600)
                       + 17'({11'd0, s_minute_now} * 17'd60)
                       + 17'({11'd0, s_second_now});
    end

    assign wr_entry = '{hour: s_entry_hour, minute: s_entry_minute,
                        etype: s_entry_type, sound: s_entry_sound};
    assign wr_en    = accept && (s_kind == KIND_WRITE) && (int'(s_entry_index) < MAX_ENTRIES);

    tdalm_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(s_entry_index)),
        .wr_data (wr_entry),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    tdalm_eval u_eval (
        .entry (rd_entry),
        .now   (now_reg),
        .best  (best_reg),
        .res   (ev)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == KIND_TICK && tick_active) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outcome of the finished scan
    assign fire = active_reg && fire_ok_reg && found_reg;

    always_comb begin
        mode_after = mode_reg;
        if (fire && mode_reg == MODE_TODAY && !best_reg.have_m) begin
            mode_after = MODE_ON;
        end
    end

    assign mode_wr = (cfg_wr_data[1:0] == 2'd3) ? MODE_OFF : cfg_wr_data[1:0];

    // configuration and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            mode_reg     <= MODE_OFF;
            last_day_reg <= NO_DAY;
            last_min_reg <= NO_MINUTE;
        end else begin
            if (finish) begin
                mode_reg <= mode_after;
                if (fire) begin
                    last_day_reg <= day_reg;
                    last_min_reg <= now_reg.cur_min;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENTRY_COUNT: begin
                        if (int'(cfg_wr_data) > MAX_ENTRIES) begin
                            cnt_reg <= CNT_W'(MAX_ENTRIES);
                        end else begin
                            cnt_reg <= CNT_W'(cfg_wr_data);
                        end
                    end
                    REG_MODE_SETTING: begin
                        mode_reg <= mode_wr;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            active_reg  <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_SCAN);
            if (accept) begin
                active_reg <= (s_kind == KIND_TICK) && tick_active;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg         <= '0;
            fire_ok_reg     <= !((last_day_reg == s_day_of_year) &&
                                 (last_min_reg == now_in.cur_min));
            stream_reg      <= s_stream_connected;
            day_reg         <= s_day_of_year;
            now_reg         <= now_in;
            best_reg        <= '0;
            found_reg       <= 1'b0;
            found_type_reg  <= 1'b0;
            found_sound_reg <= '0;
        end else begin
            if (state_reg == ST_SCAN) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (rd_pend_reg) begin
                if (ev.match && !found_reg) begin
                    found_reg       <= 1'b1;
                    found_type_reg  <= rd_entry.etype;
                    found_sound_reg <= rd_entry.sound;
                end
                if (ev.sec_upd) begin
                    best_reg.have_s <= 1'b1;
                    best_reg.best_s <= ev.sec_val;
                end
                if (ev.min_upd) begin
                    best_reg.have_m <= 1'b1;
                    best_reg.best_m <= ev.min_val;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            ring_reg       <= fire;
            ring_type_reg  <= fire ? found_type_reg : 1'b0;
            ring_sound_reg <= fire ? found_sound_reg : 8'd0;
            play_local_reg <= fire && !stream_reg;
            secs_reg       <= (active_reg && best_reg.have_s) ? {1'b0, best_reg.best_s} : '1;
            nmin_reg       <= (active_reg && best_reg.have_m) ? {1'b0, best_reg.best_m} : '1;
            mode_now_reg   <= mode_after;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ring            = ring_reg;
    assign m_ring_type       = ring_type_reg;
    assign m_ring_sound      = ring_sound_reg;
    assign m_play_local      = play_local_reg;
    assign m_seconds_to_next = $signed(secs_reg);
    assign m_next_minute     = $signed(nmin_reg);
    assign m_mode_now        = mode_now_reg;

endmodule
